// ----- hw/rtl/bwct_pkg.sv -----
// bwct_pkg: shared widths and outcome codes for the bracket winner count tree
// used by the channel interfaces, the core and its checker; no dependencies
package bwct_pkg;

	// payload field widths
	localparam int unsigned GAME_W = 10;
	localparam int unsigned MODE_W = 2;
	localparam int unsigned WIN_W  = 11;

	// outcome modes; the fourth code behaves as right wins
	localparam logic [MODE_W-1:0] MODE_LEFT   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RIGHT  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_EITHER = 2'd2;

	typedef logic [GAME_W-1:0] game_t;
	typedef logic [MODE_W-1:0] mode_t;
	typedef logic [WIN_W-1:0]  win_t;

endpackage

// ----- hw/rtl/bwct_ifs.sv -----
// bwct channel interfaces: update request channel and result channel
// depends on bwct_pkg for payload types
interface bwct_in_if;
	logic                 valid;
	logic                 ready;
	bwct_pkg::game_t      game_number;
	bwct_pkg::mode_t      outcome_mode;

	modport source (output valid, output game_number, output outcome_mode, input ready);
	modport sink   (input valid, input game_number, input outcome_mode, output ready);
endinterface

interface bwct_out_if;
	logic                 valid;
	logic                 ready;
	bwct_pkg::win_t       possible_winners;

	modport source (output valid, output possible_winners, input ready);
	modport sink   (input valid, input possible_winners, output ready);
endinterface

// ----- hw/rtl/bracket_winner_count_tree_core.sv -----
// bracket_winner_count_tree_core: possible-winner counter over a bracket tree
// depends on bwct_pkg, bwct_ifs (channels) and bwct_ram (mode and count stores)
//
// Usage:
//   in_ch carries one update per transfer: game_number (1-based, lowest level
//   first, left to right) and outcome_mode (left, right or either wins).
//   out_ch returns one result per update: the number of leaves that can still
//   win at the root, low 11 bits.
//   The mode store and the count store are rams indexed by heap node. An
//   update writes the mode, reads the left child count, then climbs one level
//   per cycle through a read-modify-write of the parent count up to the root.
//   An in-range update passes through S_LEFT and S_WALK to S_OUT, and an
//   out-of-range game number changes nothing and goes straight to S_OUT; in
//   S_OUT the root count enters the output register once that register is
//   free. One update is in flight at a time; in_ch.ready is high only while
//   the core is idle, so a new update is taken only after the previous one
//   has left S_OUT.
//   After reset the core sweeps both rams, one node a cycle, over nodes 1 to
//   2^TREE_LEVELS - 1, setting every mode to either and every count to
//   its subtree size; in_ch.ready stays low during the sweep.
//   The result sits in an output register; a new update may be taken while it
//   waits, and that update holds before its own result until out_ch.ready.
module bracket_winner_count_tree_core #(
	parameter int unsigned TREE_LEVELS = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	bwct_in_if.sink    in_ch,
	bwct_out_if.source out_ch
);

	localparam int unsigned L  = TREE_LEVELS;
	localparam int unsigned CW = TREE_LEVELS + 1;
	localparam int unsigned XW = ((TREE_LEVELS > bwct_pkg::GAME_W) ?
		TREE_LEVELS : bwct_pkg::GAME_W) + 1;
	localparam int unsigned EW = (CW > bwct_pkg::WIN_W) ? CW : bwct_pkg::WIN_W;
	localparam int unsigned DEPTH = 2 ** TREE_LEVELS;
	localparam logic [XW-1:0] LEAF_X = XW'(2 ** TREE_LEVELS);
	localparam logic [CW-1:0] FULL_CNT = CW'(2 ** TREE_LEVELS);
	localparam logic [CW-1:0] ONE_CNT = CW'(1);
	localparam logic [L-1:0] ROOT = L'(1);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_LEFT  = 3'd2;
	localparam logic [2:0] S_WALK  = 3'd3;
	localparam logic [2:0] S_OUT   = 3'd4;

	logic [2:0]    state_q;
	logic [L-1:0]  clr_q;
	logic [CW-1:0] size_q;
	logic [L:0]    c_q;
	logic [CW-1:0] cc_q;
	logic [CW-1:0] root_q;
	logic          out_valid_q;
	bwct_pkg::win_t out_win_q;

	logic           in_xfer;
	logic           game_ok;
	logic [XW-1:0]  dist_x;
	logic [L-1:0]   dist_l;
	logic [L-1:0]   smear;
	logic [L-1:0]   dec_node;
	logic [L:0]     dec_child;

	logic                     mode_we;
	logic [L-1:0]             mode_waddr;
	bwct_pkg::mode_t          mode_wdata;
	logic [L-1:0]             mode_raddr;
	bwct_pkg::mode_t          mode_rdata;
	logic                     cnt_we;
	logic [L-1:0]             cnt_waddr;
	logic [CW-1:0]            cnt_wdata;
	logic [L-1:0]             cnt_raddr;
	logic [CW-1:0]            cnt_rdata;

	logic [L:0]    rd_base;
	logic [L-1:0]  parent;
	logic [CW-1:0] sib_cnt;
	logic [CW-1:0] left_cnt;
	logic [CW-1:0] right_cnt;
	logic [CW-1:0] new_cnt;
	logic [EW-1:0] root_ext;
	logic          out_free;

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_xfer     = in_ch.valid && in_ch.ready;

	// game number to heap node: distance from the leaf base, bits below the msb flipped
	assign game_ok = (in_ch.game_number != '0) && (XW'(in_ch.game_number) < LEAF_X);
	assign dist_x  = LEAF_X - XW'(in_ch.game_number);
	assign dist_l  = dist_x[L-1:0];

	always_comb begin
		smear[L-1] = dist_l[L-1];
		for (int b = int'(L) - 2; b >= 0; b--) begin
			smear[b] = smear[b+1] | dist_l[b];
		end
	end

	assign dec_node  = dist_l ^ (smear >> 1);
	assign dec_child = {dec_node, 1'b0};

	// read addresses: left child count on transfer, then sibling count and parent mode of the node being climbed
	assign rd_base    = (state_q == S_LEFT) ? c_q : {1'b0, c_q[L:1]};
	assign mode_raddr = rd_base[L:1];
	assign cnt_raddr  = (state_q == S_IDLE) ? dec_child[L-1:0] : (rd_base[L-1:0] ^ ROOT);

	// recompute the parent from the climbed child and its sibling
	assign parent    = c_q[L:1];
	assign sib_cnt   = c_q[L] ? ONE_CNT : cnt_rdata;
	assign left_cnt  = c_q[0] ? sib_cnt : cc_q;
	assign right_cnt = c_q[0] ? cc_q : sib_cnt;

	always_comb begin
		case (mode_rdata)
			bwct_pkg::MODE_EITHER: new_cnt = left_cnt + right_cnt;
			bwct_pkg::MODE_LEFT:   new_cnt = left_cnt;
			default:               new_cnt = right_cnt;
		endcase
	end

	// ram write ports: clearing sweep, mode store on transfer, count on climb
	always_comb begin
		mode_we    = 1'b0;
		mode_waddr = dec_node;
		mode_wdata = in_ch.outcome_mode;
		cnt_we     = 1'b0;
		cnt_waddr  = parent;
		cnt_wdata  = new_cnt;
		if (state_q == S_CLEAR) begin
			mode_we    = 1'b1;
			mode_waddr = clr_q;
			mode_wdata = bwct_pkg::MODE_EITHER;
			cnt_we     = 1'b1;
			cnt_waddr  = clr_q;
			cnt_wdata  = size_q;
		end else if (state_q == S_IDLE) begin
			mode_we = in_xfer && game_ok;
		end else if (state_q == S_WALK) begin
			cnt_we = 1'b1;
		end
	end

	bwct_ram #(
		.WIDTH (bwct_pkg::MODE_W),
		.DEPTH (DEPTH)
	) u_mode_ram (
		.clk   (clk),
		.we    (mode_we),
		.waddr (mode_waddr),
		.wdata (mode_wdata),
		.raddr (mode_raddr),
		.rdata (mode_rdata)
	);

	bwct_ram #(
		.WIDTH (CW),
		.DEPTH (DEPTH)
	) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	assign root_ext = EW'(root_q);
	assign out_free = !out_valid_q || out_ch.ready;

	// sequencer: sweep, accept, fetch left child, climb, hand off result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= ROOT;
			size_q  <= FULL_CNT;
			root_q  <= FULL_CNT;
			c_q     <= '0;
			cc_q    <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (&clr_q) begin
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + ROOT;
						if ((clr_q & (clr_q + ROOT)) == '0) begin
							size_q <= size_q >> 1;
						end
					end
				end
				S_IDLE: begin
					if (in_xfer) begin
						c_q     <= dec_child;
						state_q <= game_ok ? S_LEFT : S_OUT;
					end
				end
				S_LEFT: begin
					cc_q    <= c_q[L] ? ONE_CNT : cnt_rdata;
					state_q <= S_WALK;
				end
				S_WALK: begin
					cc_q <= new_cnt;
					c_q  <= {1'b0, parent};
					if (parent == ROOT) begin
						root_q  <= new_cnt;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			out_win_q <= root_ext[bwct_pkg::WIN_W-1:0];
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.possible_winners = out_win_q;

endmodule

// ----- hw/rtl/bwct_ram.sv -----
// bwct_ram: generic single write port, single read port ram with registered read
// no dependencies
module bwct_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/bwct_checker.sv -----
// bwct_checker: port-level assertions for the bracket winner count core
// depends on bwct_pkg; bound to bracket_winner_count_tree_core below
module bwct_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input bwct_pkg::win_t possible_winners
);

	logic [1:0] pending_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// updates taken whose result has not been transferred yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			pending_q <= pending_q + 2'd1;
		end else if (out_xfer && !in_xfer) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	// a shown result always belongs to a taken update
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("result shown with no update outstanding");

	// at most one update in the tree and one waiting in the output register
	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more than two updates outstanding");

	// a transfer moves the core out of idle, so updates never transfer back to back
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("update taken in consecutive cycles");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(possible_winners))
		else $error("stalled result dropped or changed");

endmodule

bind bracket_winner_count_tree_core bwct_checker u_bwct_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_ch.valid),
	.in_ready         (in_ch.ready),
	.out_valid        (out_ch.valid),
	.out_ready        (out_ch.ready),
	.possible_winners (out_ch.possible_winners)
);

// ----- tb/sv/tb_bracket_winner_count_tree_core.sv -----
`timescale 1ns / 1ps
// tb_bracket_winner_count_tree_core: self-checking bench for the bracket winner count tree
// keeps its own bracket tree to predict the root count of every update; needs bwct_pkg,
// bwct_ifs and bracket_winner_count_tree_core
module tb_bracket_winner_count_tree_core;

	localparam int unsigned TREE_LEVELS = 10;
	localparam int unsigned LEAF_BASE   = 1 << TREE_LEVELS;
	localparam int unsigned RANDOM_UPDATES = 850;
	localparam int unsigned CYCLE_LIMIT    = 400000;
	localparam int unsigned HOLD_AFTER     = 300;
	localparam int unsigned HOLD_CYCLES    = 400;
	localparam int unsigned DRAIN_CYCLES   = 20;
	localparam int unsigned MAX_REPORTS    = 10;
	// fourth mode code, acts as right wins
	localparam bwct_pkg::mode_t MODE_RIGHT_ALT = 2'd3;
	// games of the top seven heap levels, where updates move the root count most
	localparam int unsigned UPPER_GAME_FIRST = LEAF_BASE - 128 + 1;

	typedef struct packed {
		bwct_pkg::game_t game;
		bwct_pkg::mode_t mode;
	} update_t;

	logic clk = 1'b0;
	logic arst_n;

	bwct_in_if  in_ch ();
	bwct_out_if out_ch ();

	bracket_winner_count_tree_core #(
		.TREE_LEVELS(TREE_LEVELS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch)
	);

	always #10 clk = ~clk;

	// bracket state: mode and reachable leaf count per heap node
	bwct_pkg::mode_t bracket_mode[LEAF_BASE];
	int unsigned     bracket_count[LEAF_BASE];

	update_t        pending_updates[$];
	bwct_pkg::win_t expected_winners[$];

	int unsigned updates_sent;
	int unsigned mismatch_count;
	int unsigned cycle_count;

	function automatic int unsigned reach_count(int unsigned node);
		if (node >= LEAF_BASE)
			return 1;
		return bracket_count[node];
	endfunction

	function automatic void refresh_node(int unsigned node);
		int unsigned lc;
		int unsigned rc;
		lc = reach_count(2 * node);
		rc = reach_count(2 * node + 1);
		case (bracket_mode[node])
			bwct_pkg::MODE_EITHER: bracket_count[node] = lc + rc;
			bwct_pkg::MODE_LEFT:   bracket_count[node] = lc;
			default:               bracket_count[node] = rc;
		endcase
	endfunction

	function automatic void clear_bracket();
		for (int unsigned j = LEAF_BASE - 1; j >= 1; j--) begin
			bracket_mode[j] = bwct_pkg::MODE_EITHER;
			refresh_node(j);
		end
	endfunction

	// store the mode, climb to the root, return the masked root count
	function automatic bwct_pkg::win_t apply_update(bwct_pkg::game_t game,
		bwct_pkg::mode_t mode);
		int unsigned rest;
		int unsigned node;
		int unsigned span;
		int lvl;
		node = 0;
		if (game >= 1 && game <= LEAF_BASE - 1) begin
			rest = game - 1;
			for (lvl = TREE_LEVELS - 1; lvl >= 0; lvl--) begin
				span = 1 << lvl;
				if (rest < span) begin
					node = span + rest;
					break;
				end
				rest -= span;
			end
			bracket_mode[node] = mode;
			while (node >= 1) begin
				refresh_node(node);
				node >>= 1;
			end
		end
		return bwct_pkg::win_t'(bracket_count[1]);
	endfunction

	function automatic void queue_update(bwct_pkg::game_t game, bwct_pkg::mode_t mode);
		update_t u;
		u.game = game;
		u.mode = mode;
		pending_updates.push_back(u);
	endfunction

	// mostly upper games so the root count swings, some anywhere, a few out of range
	function automatic void queue_random_update();
		bwct_pkg::game_t game;
		bwct_pkg::mode_t mode;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 4)
			game = '0;
		else if (pick < 55)
			game = bwct_pkg::game_t'($urandom_range(UPPER_GAME_FIRST, LEAF_BASE - 1));
		else
			game = bwct_pkg::game_t'($urandom_range(1, LEAF_BASE - 1));
		pick = $urandom_range(0, 99);
		if (pick < 45)
			mode = bwct_pkg::MODE_EITHER;
		else if (pick < 70)
			mode = bwct_pkg::MODE_LEFT;
		else if (pick < 92)
			mode = bwct_pkg::MODE_RIGHT;
		else
			mode = MODE_RIGHT_ALT;
		queue_update(game, mode);
	endfunction

	task automatic note_mismatch(bit has_want, bwct_pkg::win_t want, bwct_pkg::win_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			if (has_want)
				$display("mismatch possible_winners: expected %0d, got %0d", want, got);
			else
				$display("unexpected result possible_winners %0d", got);
		end
	endtask

	// driver: bursts of transfers separated by random gaps
	int unsigned burst_left = 1;
	int unsigned gap_left;

	always @(posedge clk or negedge arst_n) begin : update_driver
		update_t nxt;
		logic    take;
		if (!arst_n) begin
			in_ch.valid        <= 1'b0;
			in_ch.game_number  <= '0;
			in_ch.outcome_mode <= bwct_pkg::MODE_EITHER;
			burst_left = $urandom_range(1, 12);
			gap_left   = 0;
		end else begin
			take = in_ch.valid && in_ch.ready;
			if (take) begin
				expected_winners.push_back(apply_update(in_ch.game_number, in_ch.outcome_mode));
				updates_sent++;
			end
			if (!in_ch.valid || take) begin
				if (gap_left > 0) begin
					gap_left--;
					in_ch.valid <= 1'b0;
				end else if (pending_updates.size() > 0) begin
					nxt = pending_updates.pop_front();
					in_ch.valid        <= 1'b1;
					in_ch.game_number  <= nxt.game;
					in_ch.outcome_mode <= nxt.mode;
					burst_left--;
					if (burst_left == 0) begin
						// some bursts run long with no idling at all
						burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
						                                         : $urandom_range(1, 12);
						gap_left = $urandom_range(1, 20);
					end
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with its own stall pattern and one long hold-off
	int unsigned stall_style;
	int unsigned segment_left;
	int unsigned hold_left;
	bit          hold_done;

	always @(posedge clk or negedge arst_n) begin : result_monitor
		bwct_pkg::win_t want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_style  = 0;
			segment_left = 0;
			hold_left    = 0;
			hold_done    = 1'b0;
		end else begin
			// check each transfer against the oldest prediction
			if (out_ch.valid && out_ch.ready) begin
				if (expected_winners.size() == 0) begin
					note_mismatch(1'b0, '0, out_ch.possible_winners);
				end else begin
					want = expected_winners.pop_front();
					if (out_ch.possible_winners !== want)
						note_mismatch(1'b1, want, out_ch.possible_winners);
				end
			end
			if (!hold_done && updates_sent >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (segment_left == 0) begin
				stall_style  = $urandom_range(0, 3);
				segment_left = $urandom_range(10, 80);
			end
			segment_left--;
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				case (stall_style)
					0:       out_ch.ready <= 1'b1;
					1:       out_ch.ready <= ($urandom_range(0, 1) == 0);
					2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
					default: out_ch.ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n             = 1'b0;
		in_ch.valid        = 1'b0;
		in_ch.game_number  = '0;
		in_ch.outcome_mode = bwct_pkg::MODE_EITHER;
		out_ch.ready       = 1'b0;
		updates_sent   = 0;
		mismatch_count = 0;
		cycle_count    = 0;
		clear_bracket();

		// directed: out-of-range game, root in every mode, lowest-level edges, children of root
		queue_update(bwct_pkg::game_t'(0), bwct_pkg::MODE_EITHER);
		queue_update(bwct_pkg::game_t'(LEAF_BASE - 1), bwct_pkg::MODE_LEFT);
		queue_update(bwct_pkg::game_t'(LEAF_BASE - 1), bwct_pkg::MODE_RIGHT);
		queue_update(bwct_pkg::game_t'(LEAF_BASE - 1), MODE_RIGHT_ALT);
		queue_update(bwct_pkg::game_t'(LEAF_BASE - 1), bwct_pkg::MODE_EITHER);
		queue_update(bwct_pkg::game_t'(1), bwct_pkg::MODE_LEFT);
		queue_update(bwct_pkg::game_t'(LEAF_BASE / 2), bwct_pkg::MODE_RIGHT);
		queue_update(bwct_pkg::game_t'(LEAF_BASE / 2 + 1), MODE_RIGHT_ALT);
		queue_update(bwct_pkg::game_t'(LEAF_BASE / 2 + LEAF_BASE / 4), bwct_pkg::MODE_LEFT);
		queue_update(bwct_pkg::game_t'(LEAF_BASE - 3), bwct_pkg::MODE_RIGHT);
		queue_update(bwct_pkg::game_t'(LEAF_BASE - 2), bwct_pkg::MODE_LEFT);
		queue_update(bwct_pkg::game_t'(LEAF_BASE - 1), bwct_pkg::MODE_LEFT);
		queue_update(bwct_pkg::game_t'(0), bwct_pkg::MODE_LEFT);
		queue_update(bwct_pkg::game_t'(0), bwct_pkg::MODE_RIGHT);
		queue_update(bwct_pkg::game_t'(0), MODE_RIGHT_ALT);
		queue_update(bwct_pkg::game_t'(LEAF_BASE - 1), bwct_pkg::MODE_RIGHT);
		queue_update(bwct_pkg::game_t'(LEAF_BASE - 2), bwct_pkg::MODE_EITHER);
		queue_update(bwct_pkg::game_t'(LEAF_BASE - 3), bwct_pkg::MODE_EITHER);
		queue_update(bwct_pkg::game_t'(1), bwct_pkg::MODE_EITHER);
		queue_update(bwct_pkg::game_t'(LEAF_BASE / 2), bwct_pkg::MODE_EITHER);
		queue_update(bwct_pkg::game_t'(LEAF_BASE / 2 + 1), bwct_pkg::MODE_EITHER);
		queue_update(bwct_pkg::game_t'(LEAF_BASE - 1), bwct_pkg::MODE_EITHER);

		for (int unsigned k = 0; k < RANDOM_UPDATES; k++)
			queue_random_update();

		// reset once, released away from the clock edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_updates.size() != 0 || in_ch.valid)
			@(posedge clk);
		while (expected_winners.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && expected_winners.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
